FILE: sv/kht_pkg.sv
// shared constants, types and codes of the keyed handle table
package kht_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int KEY_W    = 31;
   localparam int NKEY_W   = 32;
   localparam int OP_W     = 3;
   localparam int IDX_W    = 4;
   localparam int DIN_W    = 32;
   localparam int STATUS_W = 2;
   localparam int LIVE_W   = 5;
   localparam int IDX_CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [KEY_W-1:0]      key_type;
   typedef logic [NKEY_W-1:0]     nkey_type;
   typedef logic [OP_W-1:0]       op_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [DIN_W-1:0]      din_type;
   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic [STATUS_W-1:0]   status_type;
   typedef logic [LIVE_W-1:0]     live_type;

   localparam op_type OP_INSERT = 3'd0;
   localparam op_type OP_REMOVE = 3'd1;
   localparam op_type OP_READ   = 3'd2;
   localparam op_type OP_WRITE  = 3'd3;
   localparam op_type OP_INDEX  = 3'd4;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_MISS      = 2'd1;
   localparam status_type ST_FULL      = 2'd2;
   localparam status_type ST_EXHAUSTED = 2'd3;

   localparam nkey_type KEY_LIMIT = 32'h8000_0000;

   typedef struct packed {
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      key_type  wr_key;
      word_type wr_word;
   } mem_req_type;

   typedef struct packed {
      status_type status;
      key_type    result_key;
      din_type    read_data;
      live_type   live_count;
   } result_type;

endpackage

FILE: sv/kht_if.sv
// request and response channel interfaces
interface kht_req_if import kht_pkg::*; ();
   logic    valid;
   logic    ready;
   op_type  operation;
   key_type item_key;
   idx_type entry_index;
   din_type data_in;

   modport source (output valid, operation, item_key, entry_index, data_in, input ready);
   modport sink (input valid, operation, item_key, entry_index, data_in, output ready);
endinterface

interface kht_rsp_if import kht_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;
   key_type    result_key;
   din_type    read_data;
   live_type   live_count;

   modport source (output valid, status, result_key, read_data, live_count, input ready);
   modport sink (input valid, status, result_key, read_data, live_count, output ready);
endinterface

FILE: sv/kht_ram.sv
// generic single-write, single-read ram with registered read data
module kht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: sv/kht_engine.sv
// sequencer that scans, updates and compacts the entry memories
module kht_engine import kht_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   kht_req_if.sink     req_ch,
   output mem_req_type mem_req,
   input  key_type     key_rd,
   input  word_type    word_rd,
   output logic        res_valid,
   output result_type  res,
   input  logic        res_taken
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_DISPATCH = 6'b000010,
      ST_SCAN     = 6'b000100,
      ST_SHIFT    = 6'b001000,
      ST_INDEX    = 6'b010000,
      ST_DONE     = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   cnt_type    held_ff, held_in;
   nkey_type   next_key_ff, next_key_in;
   cnt_type    ptr_ff, ptr_in;
   logic       pend_ff, pend_in;
   addr_type   pend_addr_ff, pend_addr_in;
   op_type     op_ff, op_in;
   key_type    key_ff, key_in;
   idx_type    idx_ff, idx_in;
   din_type    data_ff, data_in;
   status_type status_ff, status_in;
   key_type    rkey_ff, rkey_in;
   din_type    rdata_ff, rdata_in;

   logic    hit;
   cnt_type ptr_nx;

   assign hit    = pend_ff && (key_rd == key_ff);
   assign ptr_nx = ptr_ff + cnt_type'(1);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign res_valid    = (state_ff == ST_DONE);
   assign res          = '{status: status_ff, result_key: rkey_ff, read_data: rdata_ff,
                           live_count: live_type'(held_ff)};

   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      next_key_in  = next_key_ff;
      ptr_in       = ptr_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      data_in      = data_ff;
      status_in    = status_ff;
      rkey_in      = rkey_ff;
      rdata_in     = rdata_ff;
      mem_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.operation;
               key_in   = req_ch.item_key;
               idx_in   = req_ch.entry_index;
               data_in  = req_ch.data_in;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            rkey_in   = '0;
            rdata_in  = '0;
            status_in = ST_MISS;
            state_in  = ST_DONE;
            case (op_ff)
               OP_INSERT: begin
                  if (held_ff == cnt_type'(DEPTH)) begin
                     status_in = ST_FULL;
                  end else if (next_key_ff[NKEY_W-1]) begin
                     status_in = ST_EXHAUSTED;
                  end else begin
                     // new key is always the largest, so it goes at the end
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = addr_type'(held_ff);
                     mem_req.wr_key  = next_key_ff[KEY_W-1:0];
                     mem_req.wr_word = word_type'(data_ff);
                     held_in         = held_ff + cnt_type'(1);
                     next_key_in     = next_key_ff + nkey_type'(1);
                     rkey_in         = next_key_ff[KEY_W-1:0];
                     status_in       = ST_OK;
                  end
               end
               OP_REMOVE, OP_READ, OP_WRITE: begin
                  ptr_in   = '0;
                  pend_in  = 1'b0;
                  state_in = ST_SCAN;
               end
               OP_INDEX: begin
                  if (IDX_CMP_W'(idx_ff) < IDX_CMP_W'(held_ff)) begin
                     mem_req.rd_addr = addr_type'(idx_ff);
                     state_in        = ST_INDEX;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_SCAN: begin
            if (hit) begin
               status_in = ST_OK;
               state_in  = ST_DONE;
               case (op_ff)
                  OP_READ: begin
                     rdata_in = din_type'(word_rd);
                  end
                  OP_WRITE: begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = pend_addr_ff;
                     mem_req.wr_key  = key_rd;
                     mem_req.wr_word = word_type'(data_ff);
                  end
                  OP_REMOVE: begin
                     ptr_in   = cnt_type'(pend_addr_ff);
                     pend_in  = 1'b0;
                     state_in = ST_SHIFT;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end else if (ptr_ff == held_ff) begin
               // last returned entry checked without a match
               state_in = ST_DONE;
            end else begin
               mem_req.rd_addr = addr_type'(ptr_ff);
               pend_in         = 1'b1;
               pend_addr_in    = addr_type'(ptr_ff);
               ptr_in          = ptr_nx;
            end
         end
         ST_SHIFT: begin
            // entry read last cycle moves down one place
            if (pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pend_addr_ff - addr_type'(1);
               mem_req.wr_key  = key_rd;
               mem_req.wr_word = word_rd;
            end
            if (ptr_nx < held_ff) begin
               mem_req.rd_addr = addr_type'(ptr_nx);
               pend_in         = 1'b1;
               pend_addr_in    = addr_type'(ptr_nx);
               ptr_in          = ptr_nx;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  held_in  = held_ff - cnt_type'(1);
                  state_in = ST_DONE;
               end
            end
         end
         ST_INDEX: begin
            rkey_in   = key_rd;
            status_in = ST_OK;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (res_taken) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         held_ff     <= '0;
         next_key_ff <= '0;
         ptr_ff      <= '0;
         pend_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         held_ff     <= held_in;
         next_key_ff <= next_key_in;
         ptr_ff      <= ptr_in;
         pend_ff     <= pend_in;
      end
      pend_addr_ff <= pend_addr_in;
      op_ff        <= op_in;
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      data_ff      <= data_in;
      status_ff    <= status_in;
      rkey_ff      <= rkey_in;
      rdata_ff     <= rdata_in;
   end

`ifndef SYNTHESIS
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= cnt_type'(DEPTH))
      else $error("entry count above capacity");

   a_key_bound: assert property (@(posedge clock) disable iff (reset)
      next_key_ff <= KEY_LIMIT)
      else $error("key counter ran past key space");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> cnt_type'(mem_req.wr_addr) <= held_ff)
      else $error("write beyond packed entries");

   a_shift_below_top: assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en && state_ff == ST_SHIFT)
         |-> cnt_type'(mem_req.wr_addr) + cnt_type'(1) < held_ff)
      else $error("compaction wrote at or past last entry");

   a_count_then_result: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && held_ff != $past(held_ff)) |-> state_ff == ST_DONE)
      else $error("entry count changed outside completion");
`endif

endmodule

FILE: sv/keyed_handle_table_top.sv
// keyed handle table: packed sorted key/data table with response register
//
// req_ch carries one operation per transfer: insert, remove, read by key,
// write by key or key at index. rsp_ch returns exactly one result per
// request, in order, with status, assigned or found key, read data and the
// entry count after the operation.
// Keys and data live in two 16-entry synchronous rams. Searches scan them
// one entry per cycle from position 0; remove then moves later entries
// down one place per cycle through the same read and write ports.
// Path from request transfer to response valid: insert, bad index and
// unused codes finish in the dispatch state; key at index adds one ram
// read; read, write and a remove that misses scan up to held entries;
// a remove that hits also compacts the entries above the found one.
// One request is worked on at a time; a new one is taken in the cycle after
// the previous result has moved into the response register.
// Reset empties the table and restarts keys at zero; no clearing pass.
// If rsp_ch stalls, the response register holds its result, the next
// request may still complete, and then req_ch.ready stays low.
module keyed_handle_table_top import kht_pkg::*; (
   input logic       clock,
   input logic       reset,
   kht_req_if.sink   req_ch,
   kht_rsp_if.source rsp_ch
);

   mem_req_type mem_req;
   key_type     key_rd;
   word_type    word_rd;
   logic        res_valid;
   result_type  res;
   logic        load;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   kht_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .mem_req   (mem_req),
      .key_rd    (key_rd),
      .word_rd   (word_rd),
      .res_valid (res_valid),
      .res       (res),
      .res_taken (load)
   );

   kht_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_key),
      .rd_addr (mem_req.rd_addr),
      .rd_data (key_rd)
   );

   kht_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_word_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_word),
      .rd_addr (mem_req.rd_addr),
      .rd_data (word_rd)
   );

   // response register is free when empty or being drained this cycle
   assign load         = res_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_ff.status;
   assign rsp_ch.result_key = rsp_ff.result_key;
   assign rsp_ch.read_data  = rsp_ff.read_data;
   assign rsp_ch.live_count = rsp_ff.live_count;

endmodule

FILE: verif/kht_result_checker.sv
// result checker for the keyed handle table: predicts each response and compares it
module kht_result_checker import kht_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   kht_req_if       req_ch,
   kht_rsp_if       rsp_ch,
   output int       mismatches,
   output int       pending,
   output nkey_type next_handle
);

   key_type    table_keys [DEPTH];
   word_type   table_words [DEPTH];
   cnt_type    held;
   nkey_type   key_ctr;
   result_type awaited_results [$];
   result_type want;

   initial mismatches = 0;

   assign next_handle = key_ctr;

   // applies one table operation to the shadow table and returns its response
   function automatic result_type apply_table_op(op_type op, key_type k, idx_type ix,
                                                 din_type d);
      result_type r;
      int pos;
      r = '0;
      r.status = ST_MISS;
      pos = -1;
      for (int i = 0; i < int'(held); i++) begin
         if (pos < 0 && table_keys[i] == k) pos = i;
      end
      case (op)
         OP_INSERT: begin
            if (int'(held) >= DEPTH) begin
               r.status = ST_FULL;
            end else if (key_ctr >= KEY_LIMIT) begin
               r.status = ST_EXHAUSTED;
            end else begin
               table_keys[addr_type'(held)] = key_type'(key_ctr);
               table_words[addr_type'(held)] = word_type'(d);
               r.result_key = key_type'(key_ctr);
               held = held + 1'b1;
               key_ctr = key_ctr + 1'b1;
               r.status = ST_OK;
            end
         end
         OP_REMOVE: begin
            if (pos >= 0) begin
               // close the gap left by the removed entry
               for (int i = pos; i + 1 < int'(held); i++) begin
                  table_keys[i] = table_keys[i + 1];
                  table_words[i] = table_words[i + 1];
               end
               held = held - 1'b1;
               r.status = ST_OK;
            end
         end
         OP_READ: begin
            if (pos >= 0) begin
               r.read_data = din_type'(table_words[pos]);
               r.status = ST_OK;
            end
         end
         OP_WRITE: begin
            if (pos >= 0) begin
               table_words[pos] = word_type'(d);
               r.status = ST_OK;
            end
         end
         OP_INDEX: begin
            if (int'(ix) < int'(held)) begin
               r.result_key = table_keys[ix];
               r.status = ST_OK;
            end
         end
         default: ;
      endcase
      r.live_count = live_type'(held);
      return r;
   endfunction

   task automatic check_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %0h, got %0h", $time, field, exp_v, act_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held = '0;
         key_ctr = '0;
         awaited_results.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: response with none expected, expected none, got %0h %0h %0h %0h",
                        $time, rsp_ch.status, rsp_ch.result_key, rsp_ch.read_data,
                        rsp_ch.live_count);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_ch.status));
               check_field("result_key", 32'(want.result_key), 32'(rsp_ch.result_key));
               check_field("read_data", 32'(want.read_data), 32'(rsp_ch.read_data));
               check_field("live_count", 32'(want.live_count), 32'(rsp_ch.live_count));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            awaited_results.push_back(apply_table_op(req_ch.operation, req_ch.item_key,
                                                     req_ch.entry_index, req_ch.data_in));
         end
      end
      pending <= awaited_results.size();
   end

endmodule

FILE: verif/testbench.sv
// top of the keyed handle table testbench: clock, reset, stimulus and verdict
module testbench;
   import kht_pkg::*;

   logic     clock;
   logic     reset;
   int       mismatches;
   int       pending;
   nkey_type next_handle;
   logic     sender_calm;
   logic     receiver_calm;
   int       responses_taken;

   kht_req_if req_ch ();
   kht_rsp_if rsp_ch ();

   keyed_handle_table_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   kht_result_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mismatches  (mismatches),
      .pending     (pending),
      .next_handle (next_handle)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // one request transfer; valid stays high afterwards unless the next one waits
   task automatic send_req(op_type op, key_type k, idx_type ix, din_type d);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.item_key <= k;
      req_ch.entry_index <= ix;
      req_ch.data_in <= d;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain_table();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // key choice leans on recently issued handles so most lookups hit
   function automatic key_type pick_key();
      int r;
      int lo;
      r = $urandom_range(0, 9);
      lo = int'(next_handle) - 24;
      if (lo < 0) lo = 0;
      if (r < 7) return key_type'($urandom_range(lo, int'(next_handle)));
      if (r == 7) return key_type'($urandom_range(0, int'(next_handle)));
      if (r == 8) return key_type'($urandom);
      return key_type'($urandom_range(0, 63));
   endfunction

   task automatic random_req();
      int pick;
      op_type op;
      pick = $urandom_range(0, 99);
      if (pick < 30) op = OP_INSERT;
      else if (pick < 52) op = OP_REMOVE;
      else if (pick < 68) op = OP_READ;
      else if (pick < 84) op = OP_WRITE;
      else if (pick < 94) op = OP_INDEX;
      else op = op_type'($urandom_range(int'(OP_INDEX) + 1, 2 ** OP_W - 1));
      send_req(op, pick_key(), idx_type'($urandom_range(0, 15)), din_type'($urandom));
   endtask

   // receiver: random stalls, one long hold-off to back the table up
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      receiver_calm = 1'b0;
      responses_taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (responses_taken % 50 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
         gap = receiver_calm ? 0 : $urandom_range(0, 16);
         if (responses_taken == 300) gap = 400;
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         responses_taken++;
      end
   end

   initial begin
      reset = 1'b1;
      sender_calm = 1'b0;
      req_ch.valid <= 1'b0;
      req_ch.operation <= OP_INSERT;
      req_ch.item_key <= '0;
      req_ch.entry_index <= '0;
      req_ch.data_in <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty table lookups and unused codes
      send_req(OP_INDEX, '0, '0, '0);
      send_req(OP_READ, '0, '0, '0);
      send_req(OP_REMOVE, '1, '1, '1);
      send_req(op_type'(int'(OP_INDEX) + 1), '1, '1, '1);
      send_req(op_type'(2 ** OP_W - 1), '0, '0, '1);
      // fill to capacity with edge data words, then one insert too many
      for (int i = 0; i < DEPTH; i++) begin
         send_req(OP_INSERT, '0, '0, (i % 4 == 0) ? 32'h0 : (i % 4 == 1) ? 32'hFFFF_FFFF :
                  (i % 4 == 2) ? 32'hAAAA_5555 : din_type'($urandom));
      end
      send_req(OP_INSERT, '0, '0, 32'h1234_5678);
      send_req(OP_WRITE, key_type'(DEPTH - 1), '0, 32'hFFFF_FFFF);
      send_req(OP_READ, key_type'(DEPTH - 1), '0, '0);
      send_req(OP_INDEX, '0, idx_type'(DEPTH - 1), '0);
      // removes in the middle, at the front and at the back
      send_req(OP_REMOVE, key_type'(7), '0, '0);
      send_req(OP_REMOVE, '0, '0, '0);
      send_req(OP_REMOVE, key_type'(DEPTH - 1), '0, '0);
      send_req(OP_INDEX, '0, idx_type'(DEPTH - 4), '0);
      send_req(OP_INDEX, '0, idx_type'(DEPTH - 3), '0);
      drain_table();

      for (int n = 0; n < 1400; n++) begin
         if (n % 50 == 0) sender_calm = ($urandom_range(0, 3) == 0);
         if (n == 700) drain_table();
         random_req();
      end

      drain_table();
      repeat (60) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #7200000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
